// ===== hw/rtl/sts_pkg.sv =====
// sts_pkg: shared types, constants and byte-class functions of the sql token scanner
// no dependencies; used by every rtl file of the block but sts_if

package sts_pkg;

  localparam int MaxStatementBytes = 65536;
  localparam int KwMaxChars        = 6;
  localparam int KwCount           = 15;
  localparam int KwTextChars       = 6;
  localparam int QDepth            = 4;

  localparam int PosW    = $clog2(MaxStatementBytes + 1);
  localparam int IlenW   = $clog2(KwMaxChars + 2);
  localparam int KwIdxW  = $clog2(KwMaxChars);
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  localparam logic [IlenW-1:0] IlenMax = IlenW'(KwMaxChars + 1);

  // token kinds
  localparam logic [5:0] KIND_END    = 6'd0;
  localparam logic [5:0] KIND_IDENT  = 6'd1;
  localparam logic [5:0] KIND_INT    = 6'd2;
  localparam logic [5:0] KIND_STR    = 6'd3;
  localparam logic [5:0] KIND_KW0    = 6'd4;
  localparam logic [5:0] KIND_NEQ    = 6'd19;
  localparam logic [5:0] KIND_LTE    = 6'd20;
  localparam logic [5:0] KIND_GTE    = 6'd21;
  localparam logic [5:0] KIND_COMMA  = 6'd22;
  localparam logic [5:0] KIND_SEMI   = 6'd23;
  localparam logic [5:0] KIND_LPAREN = 6'd24;
  localparam logic [5:0] KIND_RPAREN = 6'd25;
  localparam logic [5:0] KIND_EQ     = 6'd26;
  localparam logic [5:0] KIND_LT     = 6'd27;
  localparam logic [5:0] KIND_GT     = 6'd28;
  localparam logic [5:0] KIND_PLUS   = 6'd29;
  localparam logic [5:0] KIND_MINUS  = 6'd30;
  localparam logic [5:0] KIND_STAR   = 6'd31;
  localparam logic [5:0] KIND_SLASH  = 6'd32;
  localparam logic [5:0] KIND_DOT    = 6'd33;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_UNTERM  = 2'd2;
  localparam logic [1:0] ERR_LONG    = 2'd3;

  // characters
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_USCORE = 8'h5f;

  // keyword text, right aligned, first character in the highest used byte
  localparam logic [KwTextChars*8-1:0] KwText [KwCount] = '{
    "SELECT", "FROM", "WHERE", "INSERT", "INTO", "VALUES", "UPDATE", "SET",
    "DELETE", "CREATE", "TABLE", "BEGIN", "COMMIT", "AND", "OR"
  };
  localparam int KwLen [KwCount] = '{6, 4, 5, 6, 4, 6, 6, 3, 6, 6, 5, 5, 6, 3, 2};

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUM,
    MODE_STR,
    MODE_ESC,
    MODE_LT,
    MODE_GT
  } scan_mode_e;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [1:0]  err;
  } result_t;

  typedef struct packed {
    logic [1:0]       count;
    result_t [2:0]    res;
  } bundle_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] kind;
  } punct_t;

  typedef logic [KwMaxChars-1:0][7:0] kw_buf_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {[8'd9:8'd13], 8'd32};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'd65:8'd90], [8'd97:8'd122]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'd48:8'd57]};
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c inside {[8'd97:8'd122]}) ? c - 8'd32 : c;
  endfunction

  function automatic punct_t punct_kind(input logic [7:0] c);
    punct_t p;
    p.hit = 1'b1;
    case (c)
      8'h2c:   p.kind = KIND_COMMA;
      8'h3b:   p.kind = KIND_SEMI;
      8'h28:   p.kind = KIND_LPAREN;
      8'h29:   p.kind = KIND_RPAREN;
      CH_EQ:   p.kind = KIND_EQ;
      CH_LT:   p.kind = KIND_LT;
      CH_GT:   p.kind = KIND_GT;
      8'h2b:   p.kind = KIND_PLUS;
      8'h2d:   p.kind = KIND_MINUS;
      8'h2a:   p.kind = KIND_STAR;
      8'h2f:   p.kind = KIND_SLASH;
      8'h2e:   p.kind = KIND_DOT;
      default: begin
        p.hit  = 1'b0;
        p.kind = KIND_END;
      end
    endcase
    return p;
  endfunction

  // keyword match over the upper-cased prefix; len saturates past KwMaxChars
  function automatic logic [5:0] ident_kind(input kw_buf_t b, input logic [IlenW-1:0] len);
    logic [5:0] kind;
    logic       hit;
    kind = KIND_IDENT;
    for (int k = 0; k < KwCount; k++) begin
      hit = (len == IlenW'(KwLen[k]));
      for (int i = 0; i < KwTextChars; i++) begin
        if (i < KwLen[k]) begin
          hit = hit && (b[i] == KwText[k][(KwLen[k] - 1 - i) * 8 +: 8]);
        end
      end
      if (hit) begin
        kind = KIND_KW0 + 6'(k);
      end
    end
    return kind;
  endfunction

endpackage

// ===== hw/rtl/sts_if.sv =====
// sts_if: valid/ready channel interfaces of the sql token scanner
// byte words in, token words out; no dependencies

interface sts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, text_byte, final_byte, input ready);
  modport sink (input valid, text_byte, final_byte, output ready);
endinterface

interface sts_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [1:0]  error_code;
  logic        run_last;

  modport source (output valid, token_kind, token_start, token_length, error_code, run_last,
                  input ready);
  modport sink (input valid, token_kind, token_start, token_length, error_code, run_last,
                output ready);
endinterface

// ===== hw/rtl/sql_token_scanner.sv =====
// sql_token_scanner: top level of the streaming sql token scanner
// depends on sts_pkg, sts_if, sts_front, sts_queue and sts_back
//
//   channel  dir  handshake     word
//   in_i     in   valid/ready   text_byte, final_byte
//   out_o    out  valid/ready   token_kind, token_start, token_length, error_code, run_last
//
// one byte per cycle while each byte yields at most one token and the output is taken;
// a byte that yields more tokens holds the output register for one word per token,
// sent by the single output stage; a four-bundle queue lets the front keep taking bytes
// while the output is stalled; a token is registered in the queue, then in the output register
// rst_ni clears scan state, queue and output valid; no clearing pass is needed

module sql_token_scanner import sts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sts_in_if.sink    in_i,
  sts_out_if.source out_o
);

  logic    push;
  logic    full;
  logic    pop;
  logic    empty;
  bundle_t push_data;
  bundle_t head;

  sts_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .full_i   (full),
    .push_o   (push),
    .bundle_o (push_data)
  );

  sts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  sts_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== hw/rtl/sts_front.sv =====
// sts_front: accepts text bytes, runs the scan state machine and packs the
// tokens of each byte into one bundle; depends on sts_pkg and sts_in_if

module sts_front import sts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sts_in_if.sink      in_i,
  input  logic        full_i,
  output logic        push_o,
  output bundle_t     bundle_o
);

  scan_mode_e        mode_q, mode_d;
  logic [15:0]       tb_q, tb_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [IlenW-1:0]  ilen_q, ilen_d;
  logic              err_q, err_d;
  kw_buf_t           buf_q, buf_d;

  logic              acc;
  logic [7:0]        c;
  logic              fin;
  logic [15:0]       pos16;
  logic [15:0]       pos1;
  logic              too_long;
  logic              consumed;
  logic              halt;
  punct_t            pk;
  result_t [3:0]     cand;
  logic [3:0]        cv;
  logic [1:0]        n;

  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && !full_i;
  assign c          = in_i.text_byte;
  assign fin        = in_i.final_byte;
  assign pos16      = 16'(pos_q);
  assign pos1       = pos16 + 16'd1;
  assign too_long   = pos_q >= PosW'(MaxStatementBytes);
  assign pk         = punct_kind(c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      tb_q   <= '0;
      pos_q  <= '0;
      ilen_q <= '0;
      err_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      tb_q   <= tb_d;
      pos_q  <= pos_d;
      ilen_q <= ilen_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  always_comb begin
    mode_d   = mode_q;
    tb_d     = tb_q;
    pos_d    = pos_q;
    ilen_d   = ilen_q;
    err_d    = err_q;
    buf_d    = buf_q;
    cand     = '0;
    cv       = '0;
    consumed = 1'b0;
    halt     = 1'b0;
    n        = '0;
    bundle_o = '0;

    if (acc) begin
      if (err_q) begin
        if (fin) begin
          mode_d = MODE_IDLE;
          tb_d   = '0;
          pos_d  = '0;
          ilen_d = '0;
          err_d  = 1'b0;
        end
      end else if (too_long) begin
        cv[1]   = 1'b1;
        cand[1] = '{KIND_END, pos16, 16'd0, ERR_LONG};
        mode_d  = MODE_IDLE;
        if (fin) begin
          tb_d   = '0;
          pos_d  = '0;
          ilen_d = '0;
        end else begin
          err_d = 1'b1;
        end
      end else begin
        case (mode_q)
          MODE_STR: begin
            consumed = 1'b1;
            if (c == CH_QUOTE) begin
              cv[0]   = 1'b1;
              cand[0] = '{KIND_STR, tb_q, pos16 - tb_q, ERR_NONE};
              mode_d  = MODE_IDLE;
            end else if (c == CH_BSLASH) begin
              mode_d = MODE_ESC;
            end
          end
          MODE_ESC: begin
            consumed = 1'b1;
            mode_d   = MODE_STR;
          end
          MODE_LT: begin
            if (c == CH_GT || c == CH_EQ) begin
              consumed = 1'b1;
              cv[0]    = 1'b1;
              cand[0]  = '{(c == CH_GT) ? KIND_NEQ : KIND_LTE, tb_q, 16'd2, ERR_NONE};
              mode_d   = MODE_IDLE;
            end
          end
          MODE_GT: begin
            if (c == CH_EQ) begin
              consumed = 1'b1;
              cv[0]    = 1'b1;
              cand[0]  = '{KIND_GTE, tb_q, 16'd2, ERR_NONE};
              mode_d   = MODE_IDLE;
            end
          end
          MODE_IDENT: begin
            if (is_alpha(c) || is_digit(c) || c == CH_USCORE) begin
              consumed = 1'b1;
              if (ilen_q < IlenW'(KwMaxChars)) begin
                buf_d[ilen_q[KwIdxW-1:0]] = to_upper(c);
              end
              if (ilen_q != IlenMax) begin
                ilen_d = ilen_q + IlenW'(1);
              end
            end
          end
          MODE_NUM: begin
            consumed = is_digit(c);
          end
          default: ;
        endcase

        if (!consumed) begin
          // flush the token this byte ends
          if (mode_q == MODE_IDENT) begin
            cv[0]   = 1'b1;
            cand[0] = '{ident_kind(buf_q, ilen_q), tb_q, pos16 - tb_q, ERR_NONE};
          end else if (mode_q == MODE_NUM) begin
            cv[0]   = 1'b1;
            cand[0] = '{KIND_INT, tb_q, pos16 - tb_q, ERR_NONE};
          end else if (mode_q == MODE_LT) begin
            cv[0]   = 1'b1;
            cand[0] = '{KIND_LT, tb_q, 16'd1, ERR_NONE};
          end else if (mode_q == MODE_GT) begin
            cv[0]   = 1'b1;
            cand[0] = '{KIND_GT, tb_q, 16'd1, ERR_NONE};
          end
          mode_d = MODE_IDLE;

          if (is_space(c)) begin
            mode_d = MODE_IDLE;
          end else if (is_alpha(c) || c == CH_USCORE) begin
            mode_d   = MODE_IDENT;
            tb_d     = pos16;
            buf_d[0] = to_upper(c);
            ilen_d   = IlenW'(1);
          end else if (is_digit(c)) begin
            mode_d = MODE_NUM;
            tb_d   = pos16;
          end else if (c == CH_QUOTE) begin
            mode_d = MODE_STR;
            tb_d   = pos1;
          end else if (c == CH_LT && !fin) begin
            mode_d = MODE_LT;
            tb_d   = pos16;
          end else if (c == CH_GT && !fin) begin
            mode_d = MODE_GT;
            tb_d   = pos16;
          end else if (pk.hit) begin
            cv[1]   = 1'b1;
            cand[1] = '{pk.kind, pos16, 16'd1, ERR_NONE};
          end else begin
            cv[1]   = 1'b1;
            cand[1] = '{KIND_END, pos16, 16'd0, ERR_UNKNOWN};
            halt    = 1'b1;
            if (fin) begin
              tb_d   = '0;
              pos_d  = '0;
              ilen_d = '0;
            end else begin
              err_d = 1'b1;
            end
          end
        end

        if (!halt) begin
          pos_d = pos_q + PosW'(1);
          if (fin) begin
            if (mode_d == MODE_STR || mode_d == MODE_ESC) begin
              cv[3]   = 1'b1;
              cand[3] = '{KIND_END, tb_d, 16'd0, ERR_UNTERM};
            end else begin
              if (mode_d == MODE_IDENT) begin
                cv[2]   = 1'b1;
                cand[2] = '{ident_kind(buf_d, ilen_d), tb_d, pos1 - tb_d, ERR_NONE};
              end else if (mode_d == MODE_NUM) begin
                cv[2]   = 1'b1;
                cand[2] = '{KIND_INT, tb_d, pos1 - tb_d, ERR_NONE};
              end else if (mode_d == MODE_LT) begin
                cv[2]   = 1'b1;
                cand[2] = '{KIND_LT, tb_d, 16'd1, ERR_NONE};
              end else if (mode_d == MODE_GT) begin
                cv[2]   = 1'b1;
                cand[2] = '{KIND_GT, tb_d, 16'd1, ERR_NONE};
              end
              cv[3]   = 1'b1;
              cand[3] = '{KIND_END, pos1, 16'd0, ERR_NONE};
            end
            mode_d = MODE_IDLE;
            tb_d   = '0;
            pos_d  = '0;
            ilen_d = '0;
            err_d  = 1'b0;
          end
        end
      end
    end

    // pack the valid candidates in order, at most three per byte
    for (int j = 0; j < 4; j++) begin
      if (cv[j] && n != 2'd3) begin
        bundle_o.res[n] = cand[j];
        n = n + 2'd1;
      end
    end
    bundle_o.count = n;
  end

  assign push_o = acc && (n != 2'd0);

endmodule

// ===== hw/rtl/sts_queue.sv =====
// sts_queue: small bundle queue between the scan front and the output back
// depends on sts_pkg

module sts_queue import sts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output bundle_t head_o,
  output logic    empty_o
);

  bundle_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;

  assign full_o  = cnt_q == QCntW'(QDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/sts_back.sv =====
// sts_back: walks the queued bundles and drives one token word per cycle, while the output
// register is empty or taken; depends on sts_pkg and sts_out_if

module sts_back import sts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bundle_t  head_i,
  input  logic     empty_i,
  output logic     pop_o,
  sts_out_if.source out_o
);

  result_t     out_q;
  logic        last_q;
  logic        valid_q;
  logic [1:0]  idx_q;
  logic        load;
  logic        last;

  assign load  = !empty_i && (!valid_q || out_o.ready);
  assign last  = idx_q == (head_i.count - 2'd1);
  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= last ? 2'd0 : idx_q + 2'd1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q  <= head_i.res[idx_q];
      last_q <= last;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.token_kind   = out_q.kind;
  assign out_o.token_start  = out_q.start;
  assign out_o.token_length = out_q.length;
  assign out_o.error_code   = out_q.err;
  assign out_o.run_last     = last_q;

endmodule

// ===== hw/rtl/sts_checker.sv =====
// sts_checker: port-level assertions on the token output of the scanner
// depends on sts_pkg; bound to sql_token_scanner at the end of this file

module sts_checker import sts_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [5:0]  token_kind_i,
  input logic [15:0] token_start_i,
  input logic [15:0] token_length_i,
  input logic [1:0]  error_code_i,
  input logic        run_last_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("token word dropped while stalled");

  a_word_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(token_kind_i) && $stable(token_start_i) &&
      $stable(token_length_i) && $stable(error_code_i) && $stable(run_last_i))
    else $error("token word changed while stalled");

  a_error_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_code_i != ERR_NONE |->
      run_last_i && token_kind_i == KIND_END && token_length_i == 16'd0)
    else $error("error word is not a closing empty end word");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && token_kind_i == KIND_END |-> run_last_i && token_length_i == 16'd0)
    else $error("end word not last of its byte or not empty");

endmodule

bind sql_token_scanner sts_checker u_sts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .token_kind_i   (out_o.token_kind),
  .token_start_i  (out_o.token_start),
  .token_length_i (out_o.token_length),
  .error_code_i   (out_o.error_code),
  .run_last_i     (out_o.run_last)
);
